// ===== rtl/core/rba_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the bitmap allocator.
package rba_pkg;

  localparam int RECORD_BITS   = 256;
  localparam int MAX_RECORDS   = 64;
  localparam int MAX_ALLOC     = 16;
  localparam int WORD_W        = 64;
  localparam int POS_W         = 6;
  localparam int WORDS_PER_REC = RECORD_BITS / WORD_W;
  localparam int TOTAL_WORDS   = MAX_RECORDS * WORDS_PER_REC;
  localparam int WADDR_W       = (TOTAL_WORDS > 1) ? $clog2(TOTAL_WORDS) : 1;
  localparam int NREC_W        = 7;
  localparam int CAP_W         = 15;
  localparam int CNT_W         = $clog2(MAX_ALLOC + 1);
  localparam int K_W           = (MAX_ALLOC > 1) ? $clog2(MAX_ALLOC) : 1;
  localparam int IDX_W         = 32;
  localparam int BIT_W         = 16;
  localparam int CMDF_W        = 2;
  localparam int COUNT_W       = 5;
  localparam int IN_DATA_W     = 24;
  localparam int OUT_DATA_W    = 56;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 32;

  localparam logic [CMDF_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMDF_W-1:0] CMD_SET   = 2'd1;
  localparam logic [CMDF_W-1:0] CMD_CLEAR = 2'd2;
  localparam logic [CMDF_W-1:0] CMD_QUERY = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_RECORDS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEQ_MODE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEQ_START   = 2'd2;

  localparam logic [1:0] EK_ONE = 2'd0;
  localparam logic [1:0] EK_BUF = 2'd1;
  localparam logic [1:0] EK_SEQ = 2'd2;

  typedef struct packed {
    logic       clr_wr;
    logic       load;
    logic       rd_word;
    logic       rd_bit;
    logic       word_load;
    logic       take;
    logic       word_wr;
    logic       waddr_inc;
    logic       bmod;
    logic       emit;
    logic       emit_last;
    logic [1:0] emit_kind;
  } rba_cmd_t;

  typedef struct packed {
    logic              clr_last;
    logic [CMDF_W-1:0] in_cmd;
    logic              seq_mode;
    logic              want_zero;
    logic              cap_zero;
    logic              bit_oob;
    logic              sc_hit;
    logic              got_full;
    logic              got_zero;
    logic              word_last;
    logic              out_free;
    logic              buf_last;
    logic              seq_last;
  } rba_stat_t;

endpackage

// ===== rtl/core/record_bitmap_allocator.sv =====
// Top level of the record bitmap allocator: controller plus datapath.
// Query goes straight to its result; set/clear does one memory read and write of the word.
// Allocate reads, loads and scans one 64-bit bitmap word at a time, taking its free bits
// one by one, then issues one result per cycle unless out_tready stalls; sequential-mode
// allocate issues one per cycle too. Sync active-low reset clears control state, then a
// clearing pass zeroes the memory one word a cycle, in_tready low; config is always taken.
module record_bitmap_allocator import rba_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // cmd[1:0], bit_index[17:2], count[22:18]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // result_index[31:0], ok[32], changed[33],
                                            // free_bits[48:34]
  output logic                  out_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  rba_cmd_t  cmd;
  rba_stat_t st;

  assign cfg_ready = 1'b1;

  rba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  rba_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .st         (st)
  );

endmodule

// ===== rtl/core/rba_ctrl.sv =====
// Sequencing state machine for the bitmap allocator.
module rba_ctrl import rba_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  rba_stat_t st,
  output rba_cmd_t  cmd
);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SRD   = 4'd2;
  localparam logic [3:0] S_SLOAD = 4'd3;
  localparam logic [3:0] S_SCAN  = 4'd4;
  localparam logic [3:0] S_BRD   = 4'd5;
  localparam logic [3:0] S_BMOD  = 4'd6;
  localparam logic [3:0] S_E_ONE = 4'd7;
  localparam logic [3:0] S_E_BUF = 4'd8;
  localparam logic [3:0] S_E_SEQ = 4'd9;

  logic [3:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.emit_kind = EK_ONE;
    case (state_r)
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (st.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load = 1'b1;
          case (st.in_cmd)
            CMD_ALLOC: begin
              if (st.want_zero) state_nxt = S_E_ONE;
              else if (st.seq_mode) state_nxt = S_E_SEQ;
              else if (st.cap_zero) state_nxt = S_E_ONE;
              else state_nxt = S_SRD;
            end
            CMD_SET, CMD_CLEAR: begin
              state_nxt = st.bit_oob ? S_E_ONE : S_BRD;
            end
            default: state_nxt = S_E_ONE;
          endcase
        end
      end
      S_SRD: begin
        cmd.rd_word = 1'b1;
        state_nxt   = S_SLOAD;
      end
      S_SLOAD: begin
        cmd.word_load = 1'b1;
        state_nxt     = S_SCAN;
      end
      S_SCAN: begin
        if (st.sc_hit) begin
          cmd.take = 1'b1;
        end else begin
          // write back the word, then move on or finish
          cmd.word_wr = 1'b1;
          if (st.got_full || st.word_last) begin
            state_nxt = st.got_zero ? S_E_ONE : S_E_BUF;
          end else begin
            cmd.waddr_inc = 1'b1;
            state_nxt     = S_SRD;
          end
        end
      end
      S_BRD: begin
        cmd.rd_bit = 1'b1;
        state_nxt  = S_BMOD;
      end
      S_BMOD: begin
        cmd.bmod  = 1'b1;
        state_nxt = S_E_ONE;
      end
      S_E_ONE, S_E_BUF, S_E_SEQ: begin
        cmd.emit_last = 1'b1;
        if (state_r == S_E_BUF) begin
          cmd.emit_kind = EK_BUF;
          cmd.emit_last = st.buf_last;
        end else if (state_r == S_E_SEQ) begin
          cmd.emit_kind = EK_SEQ;
          cmd.emit_last = st.seq_last;
        end
        if (st.out_free) begin
          cmd.emit = 1'b1;
          if (cmd.emit_last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLR;
    else state_r <= state_nxt;
  end

endmodule

// ===== rtl/core/rba_dpath.sv =====
// Datapath: bitmap memory, scan word, grant buffer, counters, config and output register.
module rba_dpath import rba_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast,
  input  rba_cmd_t              cmd,
  output rba_stat_t             st
);

  logic [WORD_W-1:0]  mem [TOTAL_WORDS];
  logic [WORD_W-1:0]  rd_data_r;
  logic [WORD_W-1:0]  word_r;
  logic [WADDR_W-1:0] waddr_r;
  logic [BIT_W-1:0]   bit_r;
  logic [CMDF_W-1:0]  cmd_r;
  logic [CNT_W-1:0]   want_r, got_r, k_r;
  logic [IDX_W-1:0]   buf_r [MAX_ALLOC];
  logic               ok_r, chg_r;
  logic [NREC_W-1:0]  nrec_r;
  logic               seqm_r;
  logic [IDX_W-1:0]   next_seq_r;
  logic [CAP_W-1:0]   total_r;
  logic               out_valid_r;
  logic [IDX_W-1:0]   o_idx_r;
  logic               o_ok_r, o_chg_r, o_last_r;
  logic [CAP_W-1:0]   o_free_r;

  logic [CMDF_W-1:0]  f_cmd;
  logic [BIT_W-1:0]   f_bit;
  logic [COUNT_W-1:0] f_count;
  logic [CNT_W-1:0]   f_want;
  logic [CAP_W-1:0]   cap, free_now;
  logic               zfound;
  logic [POS_W-1:0]   zpos;
  logic [WADDR_W-1:0] bit_waddr;
  logic [POS_W-1:0]   bit_pos;
  logic [WORD_W-1:0]  bit_mask;
  logic               bit_is_set, set_op;
  logic [WADDR_W:0]   nwords;
  logic [CNT_W-1:0]   k_inc;
  logic [NREC_W-1:0]  cfg_nrec;

  assign f_cmd   = in_tdata[CMDF_W-1:0];
  assign f_bit   = in_tdata[CMDF_W +: BIT_W];
  assign f_count = in_tdata[CMDF_W+BIT_W +: COUNT_W];
  assign f_want  = (f_count > COUNT_W'(MAX_ALLOC)) ? CNT_W'(MAX_ALLOC) : CNT_W'(f_count);

  assign cap      = CAP_W'(nrec_r) * CAP_W'(RECORD_BITS);
  assign free_now = (cap > total_r) ? cap - total_r : '0;
  assign nwords   = (WADDR_W+1)'(nrec_r) * (WADDR_W+1)'(WORDS_PER_REC);

  // first free bit, most-significant first
  always_comb begin
    zfound = 1'b0;
    zpos   = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!word_r[WORD_W-1-i]) begin
        zfound = 1'b1;
        zpos   = POS_W'(i);
      end
    end
  end

  assign bit_waddr  = bit_r[POS_W +: WADDR_W];
  assign bit_pos    = bit_r[POS_W-1:0];
  assign bit_mask   = WORD_W'(1) << (POS_W'(WORD_W - 1) - bit_pos);
  assign bit_is_set = |(rd_data_r & bit_mask);
  assign set_op     = (cmd_r == CMD_SET);
  assign k_inc      = k_r + CNT_W'(1);

  always_comb begin
    st           = '0;
    st.clr_last  = (waddr_r == WADDR_W'(TOTAL_WORDS - 1));
    st.in_cmd    = f_cmd;
    st.seq_mode  = seqm_r;
    st.want_zero = (f_want == '0);
    st.cap_zero  = (nrec_r == '0);
    st.bit_oob   = ({1'b0, f_bit} >= (BIT_W+1)'(cap));
    st.sc_hit    = zfound && (got_r < want_r);
    st.got_full  = (got_r == want_r);
    st.got_zero  = (got_r == '0);
    st.word_last = (({1'b0, waddr_r} + (WADDR_W+1)'(1)) == nwords);
    st.out_free  = !out_valid_r || out_tready;
    st.buf_last  = (k_inc == got_r);
    st.seq_last  = (k_inc == want_r);
  end

  // bitmap memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) mem[waddr_r] <= '0;
    else if (cmd.word_wr) mem[waddr_r] <= word_r;
    else if (cmd.bmod) mem[bit_waddr] <= set_op ? (rd_data_r | bit_mask)
                                                : (rd_data_r & ~bit_mask);
    if (cmd.rd_word) rd_data_r <= mem[waddr_r];
    else if (cmd.rd_bit) rd_data_r <= mem[bit_waddr];
  end

  assign cfg_nrec = (cfg_data[NREC_W-1:0] > NREC_W'(MAX_RECORDS)) ? NREC_W'(MAX_RECORDS)
                                                                   : cfg_data[NREC_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waddr_r     <= '0;
      got_r       <= '0;
      want_r      <= '0;
      k_r         <= '0;
      nrec_r      <= NREC_W'(MAX_RECORDS);
      seqm_r      <= 1'b0;
      next_seq_r  <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      ok_r        <= 1'b0;
      chg_r       <= 1'b0;
      cmd_r       <= CMD_QUERY;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_NUM_RECORDS: nrec_r <= cfg_nrec;
          REG_SEQ_MODE:    seqm_r <= cfg_data[0];
          REG_SEQ_START:   next_seq_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.clr_wr && !st.clr_last) waddr_r <= waddr_r + WADDR_W'(1);
      if (cmd.load) begin
        cmd_r   <= f_cmd;
        want_r  <= f_want;
        got_r   <= '0;
        k_r     <= '0;
        waddr_r <= '0;
        ok_r    <= (f_cmd == CMD_SET || f_cmd == CMD_CLEAR) ? !st.bit_oob
                                                             : (f_cmd == CMD_QUERY);
        chg_r   <= 1'b0;
      end
      if (cmd.take) begin
        got_r   <= got_r + CNT_W'(1);
        total_r <= total_r + CAP_W'(1);
      end
      if (cmd.waddr_inc) waddr_r <= waddr_r + WADDR_W'(1);
      if (cmd.bmod) begin
        if (set_op && !bit_is_set) begin
          chg_r   <= 1'b1;
          total_r <= total_r + CAP_W'(1);
        end else if (!set_op && bit_is_set) begin
          chg_r   <= 1'b1;
          total_r <= total_r - CAP_W'(1);
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        k_r         <= cmd.emit_last ? '0 : k_inc;
        if (cmd.emit_kind == EK_SEQ) next_seq_r <= next_seq_r + IDX_W'(1);
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) bit_r <= '0;
    else if (cmd.load) bit_r <= f_bit;
    if (cmd.word_load) word_r <= rd_data_r;
    if (cmd.take) begin
      word_r[POS_W'(WORD_W - 1) - zpos] <= 1'b1;
      buf_r[got_r[K_W-1:0]] <= IDX_W'({waddr_r, zpos});
    end
    if (cmd.emit) begin
      o_free_r <= free_now;
      o_last_r <= cmd.emit_last;
      case (cmd.emit_kind)
        EK_BUF: begin
          o_idx_r <= buf_r[k_r[K_W-1:0]];
          o_ok_r  <= 1'b1;
          o_chg_r <= 1'b0;
        end
        EK_SEQ: begin
          o_idx_r <= next_seq_r;
          o_ok_r  <= 1'b1;
          o_chg_r <= 1'b0;
        end
        default: begin
          o_idx_r <= '0;
          o_ok_r  <= ok_r;
          o_chg_r <= chg_r;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = OUT_DATA_W'({o_free_r, o_chg_r, o_ok_r, o_idx_r});

endmodule
